>>> src/stts_pkg.sv
// Package with shared constants, codes and types for the timer and task scheduler.
package stts_pkg;

    localparam int MAX_TIMERS = 16;
    localparam int TASK_DEPTH = 16;
    localparam int RESULT_CAP = 32;
    localparam int SLOT_W     = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int TASK_W     = (TASK_DEPTH > 1) ? $clog2(TASK_DEPTH) : 1;
    localparam int TCNT_W     = $clog2(TASK_DEPTH + 1);
    localparam int RCNT_W     = $clog2(RESULT_CAP + 1);
    localparam int SCAN_W     = $clog2(MAX_TIMERS + 2);
    localparam int TIME_W     = 40;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Request codes.
    localparam logic [2:0] REQ_ADD   = 3'd0;
    localparam logic [2:0] REQ_CLEAR = 3'd1;
    localparam logic [2:0] REQ_TICK  = 3'd2;
    localparam logic [2:0] REQ_POST  = 3'd3;
    localparam logic [2:0] REQ_STOP  = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_ADDED = 2'd0;
    localparam logic [1:0] KIND_FULL  = 2'd1;
    localparam logic [1:0] KIND_FIRED = 2'd2;
    localparam logic [1:0] KIND_TASK  = 2'd3;

    // One timer slot.
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] due;
        logic [31:0]       period;
        logic              rpt;
        logic [31:0]       ident;
    } slot_t;

    // Candidate passed along the selection chain.
    typedef struct packed {
        logic              found;
        logic [TIME_W-1:0] due;
        logic [31:0]       ident;
        logic [SLOT_W-1:0] idx;
    } cand_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic              write;
        logic [SLOT_W-1:0] write_idx;
        slot_t             write_slot;
        logic              kill;
        logic [SLOT_W-1:0] kill_idx;
        logic              fire;
        logic [SLOT_W-1:0] fire_idx;
        logic              tick_start;
        logic [TIME_W-1:0] now;
    } cell_cmd_t;

    // Saturating add into the time count.
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [31:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W-31){1'b0}}, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

>>> src/stts_cell.sv
// One timer cell: holds a slot and merges its own candidate into the chain.
module stts_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [stts_pkg::SLOT_W-1:0] my_idx,
    input  stts_pkg::cell_cmd_t        cmd,
    input  stts_pkg::cand_t            cand_in,
    output stts_pkg::cand_t            cand_out,
    output stts_pkg::slot_t            slot
);

    logic                valid_reg;
    logic                done_reg;
    stts_pkg::slot_t     data_reg;
    stts_pkg::cand_t     cand_reg;
    logic                eligible;
    logic                better;

    assign slot = '{valid: valid_reg, due: data_reg.due, period: data_reg.period,
                    rpt: data_reg.rpt, ident: data_reg.ident};

    // A cell competes when valid, due and not yet fired on this tick.
    assign eligible = valid_reg && !done_reg && (data_reg.due <= cmd.now);
    assign better = !cand_in.found || (data_reg.due < cand_in.due) ||
                    ((data_reg.due == cand_in.due) && (data_reg.ident < cand_in.ident));

    // Registered hand-off to the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
        end
        else if (eligible && better)
        begin
            cand_reg <= '{found: 1'b1, due: data_reg.due, ident: data_reg.ident, idx: my_idx};
        end
        else
        begin
            cand_reg <= cand_in;
        end
    end
    assign cand_out = cand_reg;

    // Slot state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.tick_start)
            begin
                done_reg <= 1'b0;
            end
            if (cmd.write && cmd.write_idx == my_idx)
            begin
                valid_reg <= 1'b1;
            end
            if (cmd.kill && cmd.kill_idx == my_idx)
            begin
                valid_reg <= 1'b0;
            end
            if (cmd.fire && cmd.fire_idx == my_idx)
            begin
                done_reg <= 1'b1;
                if (!data_reg.rpt)
                begin
                    valid_reg <= 1'b0;
                end
            end
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.write && cmd.write_idx == my_idx)
        begin
            data_reg <= cmd.write_slot;
        end
        else if (cmd.fire && cmd.fire_idx == my_idx && data_reg.rpt)
        begin
            data_reg.due <= stts_pkg::sat_add(cmd.now, data_reg.period);
        end
    end

endmodule

>>> src/stts_fifo.sv
// Task tag FIFO with count, flush and single pop port.
module stts_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [15:0]                 push_tag,
    input  logic                        pop,
    input  logic                        flush,
    output logic [stts_pkg::TCNT_W-1:0] count,
    output logic [15:0]                 head_tag
);

    logic [15:0]                 mem [stts_pkg::TASK_DEPTH];
    logic [stts_pkg::TASK_W-1:0] rd_reg, rd_next;
    logic [stts_pkg::TASK_W-1:0] wr_reg, wr_next;
    logic [stts_pkg::TCNT_W-1:0] cnt_reg;

    assign count    = cnt_reg;
    assign head_tag = mem[rd_reg];

    // Pointer wrap at the depth.
    always_comb
    begin
        rd_next = (rd_reg == stts_pkg::TASK_W'(stts_pkg::TASK_DEPTH - 1)) ? '0
                  : rd_reg + stts_pkg::TASK_W'(1);
        wr_next = (wr_reg == stts_pkg::TASK_W'(stts_pkg::TASK_DEPTH - 1)) ? '0
                  : wr_reg + stts_pkg::TASK_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (flush)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (push)
        begin
            wr_reg  <= wr_next;
            cnt_reg <= cnt_reg + stts_pkg::TCNT_W'(1);
        end
        else if (pop)
        begin
            rd_reg  <= rd_next;
            cnt_reg <= cnt_reg - stts_pkg::TCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !flush)
        begin
            mem[wr_reg] <= push_tag;
        end
    end

endmodule

>>> src/software_timer_and_task_scheduler.sv
// Top level: request decode, cell chain control and result output.
//
//  channel | group  | fields (low bit first)
//  request | s_axis | tdata: req_type, delay, repeat_req, clear_id, task_tag, elapsed_ms
//  result  | m_axis | tdata: kind, timer_id, ready_tag; tlast: last
//
// A request is taken in the idle state and decoded in the next cycle, where add and
// clear search the slots; an add then loads its result in ST_OUT when the output is free.
// A tick runs one pass (chain scan plus pick) per fired timer and a last pass that finds
// none or hits the result cap, then releases queued tasks within the room left and goes idle.
// Each fired timer result is held until the next pick, so its last flag is known.
// The sequencer waits while a result sits in the stalled output register.
// Reset clears all valid bits, counts and the time; no clearing pass.
module software_timer_and_task_scheduler (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,   // req_type, delay, repeat_req, clear_id, task_tag, elapsed_ms
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [55:0]  m_axis_tdata,   // kind, timer_id, ready_tag
    output logic         m_axis_tlast    // last
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EXEC  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_PICK  = 6'b001000,
        ST_TASK  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [2:0]                      req_reg;
    logic [31:0]                     delay_reg;
    logic                            rep_reg;
    logic [31:0]                     cid_reg;
    logic [15:0]                     tag_reg;
    logic [15:0]                     elapsed_reg;
    logic [stts_pkg::TIME_W-1:0]     now_reg;
    logic [31:0]                     nid_reg;
    logic                            stop_reg;
    logic [stts_pkg::RCNT_W-1:0]     nres_reg;
    logic [stts_pkg::SCAN_W-1:0]     scan_reg;
    logic [stts_pkg::TCNT_W-1:0]     take_reg;
    logic                            ov_reg;
    logic [1:0]                      okind_reg;
    logic [31:0]                     oid_reg;
    logic [15:0]                     otag_reg;
    logic                            olast_reg;
    logic                            held_reg;
    logic [31:0]                     pend_id_reg;
    logic                            add_ok_reg;

    stts_pkg::cell_cmd_t             cmd;
    stts_pkg::cand_t                 chain [stts_pkg::MAX_TIMERS + 1];
    stts_pkg::slot_t                 slots [stts_pkg::MAX_TIMERS];
    stts_pkg::cand_t                 winner;

    logic                            free_any, hit_any;
    logic [stts_pkg::SLOT_W-1:0]     free_idx, hit_idx;
    logic                            fifo_push, fifo_pop, fifo_flush;
    logic [stts_pkg::TCNT_W-1:0]     fifo_cnt;
    logic [15:0]                     fifo_head;
    logic                            out_free;
    logic [stts_pkg::TCNT_W-1:0]     room;
    logic                            pick_more;
    logic                            out_load;
    logic [1:0]                      out_kind;
    logic [31:0]                     out_id;
    logic [15:0]                     out_tag;
    logic                            out_last;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {6'd0, otag_reg, oid_reg, okind_reg};
    assign m_axis_tlast  = olast_reg;
    assign out_free      = !ov_reg || m_axis_tready;

    // Cell chain.
    assign chain[0] = '0;
    for (genvar g = 0; g < stts_pkg::MAX_TIMERS; g++)
    begin : g_cell
        stts_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .my_idx   (stts_pkg::SLOT_W'(g)),
            .cmd      (cmd),
            .cand_in  (chain[g]),
            .cand_out (chain[g+1]),
            .slot     (slots[g])
        );
    end
    assign winner = chain[stts_pkg::MAX_TIMERS];

    // Lowest free slot and lowest matching slot.
    always_comb
    begin
        free_any = 1'b0;
        hit_any  = 1'b0;
        free_idx = '0;
        hit_idx  = '0;
        for (int i = stts_pkg::MAX_TIMERS - 1; i >= 0; i--)
        begin
            if (!slots[i].valid)
            begin
                free_any = 1'b1;
                free_idx = stts_pkg::SLOT_W'(i);
            end
            if (slots[i].valid && slots[i].ident == cid_reg)
            begin
                hit_any = 1'b1;
                hit_idx = stts_pkg::SLOT_W'(i);
            end
        end
    end

    stts_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fifo_push),
        .push_tag (tag_reg),
        .pop      (fifo_pop),
        .flush    (fifo_flush),
        .count    (fifo_cnt),
        .head_tag (fifo_head)
    );

    assign room = (stts_pkg::RCNT_W'(stts_pkg::RESULT_CAP) - nres_reg > stts_pkg::RCNT_W'(fifo_cnt))
                  ? fifo_cnt
                  : stts_pkg::TCNT_W'(stts_pkg::RCNT_W'(stts_pkg::RESULT_CAP) - nres_reg);

    // Another timer may still fire on this tick.
    assign pick_more = winner.found && (nres_reg < stts_pkg::RCNT_W'(stts_pkg::RESULT_CAP));

    // Control decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.now    = now_reg;
        cmd.write_idx  = free_idx;
        cmd.write_slot = '{valid: 1'b1, due: stts_pkg::sat_add(now_reg, delay_reg),
                           period: delay_reg, rpt: rep_reg, ident: nid_reg};
        cmd.kill_idx   = hit_idx;
        cmd.fire_idx   = winner.idx;
        fifo_push  = 1'b0;
        fifo_pop   = 1'b0;
        fifo_flush = 1'b0;
        out_load   = 1'b0;
        out_kind   = stts_pkg::KIND_ADDED;
        out_id     = '0;
        out_tag    = '0;
        out_last   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (req_reg)
                    stts_pkg::REQ_ADD:
                    begin
                        cmd.write  = free_any;
                        state_next = ST_OUT;
                    end
                    stts_pkg::REQ_CLEAR:
                    begin
                        cmd.kill = hit_any;
                    end
                    stts_pkg::REQ_TICK:
                    begin
                        if (!stop_reg)
                        begin
                            cmd.tick_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    stts_pkg::REQ_POST:
                    begin
                        fifo_push = !stop_reg &&
                                    (fifo_cnt < stts_pkg::TCNT_W'(stts_pkg::TASK_DEPTH));
                    end
                    stts_pkg::REQ_STOP:
                    begin
                        fifo_flush = 1'b1;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (scan_reg == stts_pkg::SCAN_W'(stts_pkg::MAX_TIMERS + 1))
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (pick_more)
                begin
                    if (out_free)
                    begin
                        cmd.fire   = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
                else if (!held_reg || out_free)
                begin
                    state_next = (room != '0) ? ST_TASK : ST_IDLE;
                end
                // The held timer result goes out once the next pick is known.
                if (held_reg && out_free)
                begin
                    out_load = 1'b1;
                    out_kind = stts_pkg::KIND_FIRED;
                    out_id   = pend_id_reg;
                    out_last = !pick_more && (room == '0);
                end
            end
            ST_TASK:
            begin
                if (take_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    fifo_pop = 1'b1;
                    out_load = 1'b1;
                    out_kind = stts_pkg::KIND_TASK;
                    out_tag  = fifo_head;
                    out_last = (take_reg == stts_pkg::TCNT_W'(1));
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    out_load   = 1'b1;
                    out_kind   = add_ok_reg ? stts_pkg::KIND_ADDED : stts_pkg::KIND_FULL;
                    out_id     = add_ok_reg ? nid_reg - 32'd1 : 32'd0;
                    out_last   = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            now_reg   <= '0;
            nid_reg   <= '0;
            stop_reg  <= 1'b0;
            nres_reg  <= '0;
            scan_reg  <= '0;
            take_reg  <= '0;
            held_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_EXEC:
                begin
                    nres_reg <= '0;
                    scan_reg <= '0;
                    if (req_reg == stts_pkg::REQ_ADD && free_any)
                    begin
                        nid_reg <= nid_reg + 32'd1;
                    end
                    if (req_reg == stts_pkg::REQ_STOP)
                    begin
                        stop_reg <= 1'b1;
                    end
                    if (req_reg == stts_pkg::REQ_TICK && !stop_reg)
                    begin
                        now_reg <= stts_pkg::sat_add(now_reg, {16'd0, elapsed_reg});
                    end
                end
                ST_SCAN:
                begin
                    scan_reg <= scan_reg + stts_pkg::SCAN_W'(1);
                end
                ST_PICK:
                begin
                    scan_reg <= '0;
                    if (cmd.fire)
                    begin
                        nres_reg <= nres_reg + stts_pkg::RCNT_W'(1);
                        held_reg <= 1'b1;
                    end
                    else if (!pick_more && (!held_reg || out_free))
                    begin
                        take_reg <= room;
                        held_reg <= 1'b0;
                    end
                end
                ST_TASK:
                begin
                    if (out_load)
                    begin
                        take_reg <= take_reg - stts_pkg::TCNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output valid and last flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg    <= 1'b0;
            olast_reg <= 1'b0;
        end
        else if (out_load)
        begin
            ov_reg    <= 1'b1;
            olast_reg <= out_last;
        end
        else if (m_axis_tready)
        begin
            ov_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_axis_tvalid)
        begin
            req_reg     <= s_axis_tdata[2:0];
            delay_reg   <= s_axis_tdata[34:3];
            rep_reg     <= s_axis_tdata[35];
            cid_reg     <= s_axis_tdata[67:36];
            tag_reg     <= s_axis_tdata[83:68];
            elapsed_reg <= s_axis_tdata[99:84];
        end
        if (state_reg == ST_EXEC)
        begin
            add_ok_reg <= free_any;
        end
        if (cmd.fire)
        begin
            pend_id_reg <= winner.ident;
        end
        if (out_load)
        begin
            okind_reg <= out_kind;
            oid_reg   <= out_id;
            otag_reg  <= out_tag;
        end
    end

    // The output register never reloads while a result waits.
    property p_no_overwrite;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata);
    endproperty
    assert property (p_no_overwrite) else $error("result overwritten while stalled");

    property p_busy_no_take;
        @(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready;
    endproperty
    assert property (p_busy_no_take) else $error("request taken while busy");

    property p_time_mono;
        @(posedge clk) disable iff (!rst_n)
        1'b1 |=> (now_reg >= $past(now_reg));
    endproperty
    assert property (p_time_mono) else $error("time count went backward");

endmodule
